// ===== design/mflg_pkg.sv =====
package mflg_pkg;

	localparam int NODE_BITS    = 4;
	localparam int CAP_IN_BITS  = 31;
	localparam int FLOW_BITS    = 37;
	localparam int ALU_BITS     = FLOW_BITS + 1;
	localparam int CFG_IDX_BITS = 1;

	localparam int MAX_NODES_DEF = 16;
	localparam int MAX_EDGES_DEF = 64;
	localparam int CAP_BITS_DEF  = 31;

	typedef logic [NODE_BITS-1:0]    node_t;
	typedef logic [CAP_IN_BITS-1:0]  cap_in_t;
	typedef logic [FLOW_BITS-1:0]    flow_t;
	typedef logic [ALU_BITS-1:0]     alu_word_t;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SOURCE = 1'b0,
		REG_SINK   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ALU_ADD = 2'b01,
		ALU_SUB = 2'b10
	} alu_op_t;

endpackage

// ===== design/mflg_intf.sv =====
interface mflg_edge_if;
	logic                 valid;
	logic                 ready;
	mflg_pkg::node_t      tail_node;
	mflg_pkg::node_t      head_node;
	mflg_pkg::cap_in_t    edge_capacity;
	logic                 last_edge;
	modport source (output valid, tail_node, head_node, edge_capacity, last_edge, input ready);
	modport sink (input valid, tail_node, head_node, edge_capacity, last_edge, output ready);
endinterface

interface mflg_result_if;
	logic                 valid;
	logic                 ready;
	mflg_pkg::flow_t      total_flow;
	logic                 edges_dropped;
	modport source (output valid, total_flow, edges_dropped, input ready);
	modport sink (input valid, total_flow, edges_dropped, output ready);
endinterface

interface mflg_cfg_if;
	logic                 valid;
	logic                 ready;
	mflg_pkg::cfg_idx_t   index;
	mflg_pkg::node_t      data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/max_flow_level_graph.sv =====
// Maximum flow over a small directed graph, Dinic's method.
// edge_in carries one edge per item: tail_node, head_node, edge_capacity and
// last_edge. Each edge stores a forward arc and a zero-capacity reverse arc.
// Loading writes the forward arc in the accept cycle and the reverse arc in
// S_LOAD2, one arc per cycle into the arc memories; ready is low in S_LOAD2.
// The item with last_edge set starts the flow run: BFS level build, then
// blocking-flow search with per-node cursors and an explicit path stack. Each
// arc visit is a registered memory read, then a check; each augmentation
// steps per path arc through S_MIN_RD and S_MIN_CHK for the bottleneck, then
// S_UPD_RD, S_UPD_WR1 and S_UPD_WR2 for the residual updates, and S_ACC then
// adds to the total, all on one shared adder. Run time is data dependent.
// result_out then presents total_flow and edges_dropped and holds them until
// taken; edge_in stays stalled until then. Taking the result clears the arc
// store, so the next edge starts a new graph.
// cfg writes source_node (index 0) and sink_node (index 1); it is always
// ready and must be written only while the block is idle.
// Reset clears the arc store and sets source 0, sink 1; no clearing pass.
module max_flow_level_graph #(
	parameter int MAX_NODES = mflg_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = mflg_pkg::MAX_EDGES_DEF,
	parameter int CAP_BITS  = mflg_pkg::CAP_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mflg_edge_if.sink    edge_in,
	mflg_result_if.source result_out,
	mflg_cfg_if.sink     cfg
);
	import mflg_pkg::*;

	localparam int ARCS = 2 * MAX_EDGES;
	localparam int NIW  = $clog2(MAX_NODES);
	localparam int AW   = $clog2(ARCS);
	localparam int CW   = $clog2(ARCS + 1);
	localparam int DW   = $clog2(MAX_NODES + 1);
	localparam int LW   = $clog2(MAX_NODES + 1);
	localparam logic [CAP_BITS-1:0] CAP_MAX = {CAP_BITS{1'b1}};

	typedef enum logic [18:0] {
		S_IDLE     = 19'd1 << 0,
		S_LOAD2    = 19'd1 << 1,
		S_START    = 19'd1 << 2,
		S_BFS_INIT = 19'd1 << 3,
		S_BFS_POP  = 19'd1 << 4,
		S_BFS_RD   = 19'd1 << 5,
		S_BFS_CHK  = 19'd1 << 6,
		S_BFS_DONE = 19'd1 << 7,
		S_AUG_NODE = 19'd1 << 8,
		S_AUG_CHK  = 19'd1 << 9,
		S_AUG_RD   = 19'd1 << 10,
		S_AUG_ADV  = 19'd1 << 11,
		S_MIN_RD   = 19'd1 << 12,
		S_MIN_CHK  = 19'd1 << 13,
		S_UPD_RD   = 19'd1 << 14,
		S_UPD_WR1  = 19'd1 << 15,
		S_UPD_WR2  = 19'd1 << 16,
		S_ACC      = 19'd1 << 17,
		S_OUT      = 19'd1 << 18
	} state_t;

	state_t state_q, state_d;

	// arc memories
	logic [NIW-1:0]      tgt_mem [ARCS];
	logic [AW-1:0]       par_mem [ARCS];
	logic [CAP_BITS-1:0] res_mem [ARCS];
	logic [AW-1:0]       nxt_mem [ARCS];
	logic [NIW-1:0]      tgt_rd_q;
	logic [AW-1:0]       par_rd_q;
	logic [CAP_BITS-1:0] res_rd_q;
	logic [AW-1:0]       nxt_rd_q;
	logic [ARCS-1:0]     has_next_q;

	// per-node state
	logic [AW-1:0]        first_q [MAX_NODES];
	logic [AW-1:0]        last_q [MAX_NODES];
	logic [MAX_NODES-1:0] has_arc_q;
	logic [AW-1:0]        cursor_q [MAX_NODES];
	logic [MAX_NODES-1:0] cur_ok_q;
	logic [LW-1:0]        lvl_q [MAX_NODES];
	logic [MAX_NODES-1:0] lvl_ok_q;
	logic [NIW-1:0]       queue_q [MAX_NODES];
	logic [AW-1:0]        path_arc_q [MAX_NODES];
	logic [NIW-1:0]       path_node_q [MAX_NODES];

	logic [CW-1:0]       arc_cnt_q;
	logic                drop_q;
	logic                last_q2;
	node_t               src_q, snk_q;
	logic [NIW-1:0]      u_q, v_q, u2_q;
	logic [AW-1:0]       a_q, par_q;
	logic [DW-1:0]       head_q, tail_q, depth_q, idx_q;
	logic [LW-1:0]       lvl_u_q;
	logic                lvl_u_ok_q;
	logic [CAP_BITS-1:0] b_q;
	flow_t               total_q;

	// handshakes and decode
	logic          in_acc, out_acc, bad_edge;
	logic [NIW-1:0] in_u, in_v, src_n, snk_n, qhead, t_n, pop_u, ret_u;
	logic [CAP_BITS-1:0] cap_sat;
	logic          app_en;
	logic [NIW-1:0] app_node, app_tgt;
	logic [AW-1:0] app_addr, app_par;
	logic [CAP_BITS-1:0] app_res;
	logic [AW-1:0] rd_addr;
	logic          res_we;
	logic [AW-1:0] res_wa;
	logic [CAP_BITS-1:0] res_wd;
	logic [NIW-1:0] lvl_idx;
	logic [LW-1:0] lvl_rd;
	logic          lvl_ok_rd;
	logic          aug_ok;
	logic [DW-1:0] depth_m1, idx_p1;
	logic [AW-1:0] cur_u;
	alu_op_t       alu_op;
	alu_word_t     alu_x, alu_y, alu_sum;

	assign in_acc  = edge_in.valid & edge_in.ready;
	assign out_acc = result_out.valid & result_out.ready;
	assign edge_in.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign result_out.valid = (state_q == S_OUT);
	assign result_out.total_flow = total_q;
	assign result_out.edges_dropped = drop_q;

	assign in_u  = NIW'(edge_in.tail_node);
	assign in_v  = NIW'(edge_in.head_node);
	assign src_n = NIW'(src_q);
	assign snk_n = NIW'(snk_q);
	assign bad_edge = (int'(edge_in.tail_node) >= MAX_NODES) ||
		(int'(edge_in.head_node) >= MAX_NODES) ||
		(int'(arc_cnt_q) + 2 > ARCS);
	assign cap_sat = ((edge_in.edge_capacity >> CAP_BITS) != '0) ? CAP_MAX
		: CAP_BITS'(edge_in.edge_capacity);

	assign qhead    = queue_q[head_q[NIW-1:0]];
	assign t_n      = tgt_rd_q;
	assign depth_m1 = depth_q - DW'(1);
	assign idx_p1   = idx_q + DW'(1);
	assign pop_u    = qhead;
	assign ret_u    = path_node_q[depth_m1[NIW-1:0]];
	assign cur_u    = cursor_q[u_q];

	// single level read port, address by state
	always_comb begin
		case (state_q)
			S_BFS_CHK, S_AUG_CHK: lvl_idx = t_n;
			S_BFS_POP:            lvl_idx = pop_u;
			default:              lvl_idx = u_q;
		endcase
	end
	assign lvl_rd    = lvl_q[lvl_idx];
	assign lvl_ok_rd = lvl_ok_q[lvl_idx];

	assign aug_ok = (int'(depth_q) < MAX_NODES) && (res_rd_q != '0) && lvl_u_ok_q &&
		lvl_ok_rd && (lvl_rd == lvl_u_q + LW'(1));

	// append one arc: in the accept cycle the forward arc, then the reverse arc
	always_comb begin
		app_en   = 1'b0;
		app_node = in_u;
		app_tgt  = in_v;
		app_addr = arc_cnt_q[AW-1:0];
		app_par  = AW'(arc_cnt_q + CW'(1));
		app_res  = cap_sat;
		if (state_q == S_IDLE) begin
			app_en = in_acc & ~bad_edge;
		end else if (state_q == S_LOAD2) begin
			app_en   = 1'b1;
			app_node = v_q;
			app_tgt  = u2_q;
			app_par  = AW'(arc_cnt_q - CW'(1));
			app_res  = '0;
		end
	end

	always_comb begin
		case (state_q)
			S_AUG_NODE, S_AUG_RD: rd_addr = cur_u;
			S_MIN_RD, S_UPD_RD:   rd_addr = path_arc_q[idx_q[NIW-1:0]];
			S_UPD_WR1:            rd_addr = par_rd_q;
			default:              rd_addr = a_q;
		endcase
	end

	always_comb begin
		alu_op = ALU_SUB;
		alu_x  = ALU_BITS'(res_rd_q);
		alu_y  = ALU_BITS'(b_q);
		case (state_q)
			S_UPD_WR2: alu_op = ALU_ADD;
			S_ACC: begin
				alu_op = ALU_ADD;
				alu_x  = ALU_BITS'(total_q);
			end
			default: alu_op = ALU_SUB;
		endcase
	end

	mflg_alu u_alu (
		.op  (alu_op),
		.x   (alu_x),
		.y   (alu_y),
		.sum (alu_sum)
	);

	always_comb begin
		res_we = app_en;
		res_wa = app_addr;
		res_wd = app_res;
		if (state_q == S_UPD_WR1) begin
			res_we = 1'b1;
			res_wa = a_q;
			res_wd = alu_sum[CAP_BITS-1:0];
		end else if (state_q == S_UPD_WR2) begin
			res_we = 1'b1;
			res_wa = par_q;
			res_wd = alu_sum[CAP_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (app_en) begin
			tgt_mem[app_addr] <= app_tgt;
			par_mem[app_addr] <= app_par;
			if (has_arc_q[app_node])
				nxt_mem[last_q[app_node]] <= app_addr;
		end
		if (res_we)
			res_mem[res_wa] <= res_wd;
		tgt_rd_q <= tgt_mem[rd_addr];
		par_rd_q <= par_mem[rd_addr];
		res_rd_q <= res_mem[rd_addr];
		nxt_rd_q <= nxt_mem[rd_addr];
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:
				if (in_acc) begin
					if (!bad_edge) state_d = S_LOAD2;
					else if (edge_in.last_edge) state_d = S_START;
				end
			S_LOAD2: state_d = last_q2 ? S_START : S_IDLE;
			S_START:
				if (src_q == snk_q || int'(src_q) >= MAX_NODES || int'(snk_q) >= MAX_NODES)
					state_d = S_OUT;
				else
					state_d = S_BFS_INIT;
			S_BFS_INIT: state_d = S_BFS_POP;
			S_BFS_POP:
				if (head_q == tail_q) state_d = S_BFS_DONE;
				else if (has_arc_q[pop_u]) state_d = S_BFS_RD;
			S_BFS_RD: state_d = S_BFS_CHK;
			S_BFS_CHK: state_d = has_next_q[a_q] ? S_BFS_RD : S_BFS_POP;
			S_BFS_DONE: state_d = lvl_ok_q[snk_n] ? S_AUG_NODE : S_OUT;
			S_AUG_NODE:
				if (u_q == snk_n) state_d = S_MIN_RD;
				else if (cur_ok_q[u_q]) state_d = S_AUG_CHK;
				else if (depth_q == '0) state_d = S_BFS_INIT;
				else state_d = S_AUG_RD;
			S_AUG_CHK: state_d = S_AUG_NODE;
			S_AUG_RD: state_d = S_AUG_ADV;
			S_AUG_ADV: state_d = S_AUG_NODE;
			S_MIN_RD: state_d = S_MIN_CHK;
			S_MIN_CHK: state_d = (idx_p1 == depth_q) ? S_UPD_RD : S_MIN_RD;
			S_UPD_RD: state_d = S_UPD_WR1;
			S_UPD_WR1: state_d = S_UPD_WR2;
			S_UPD_WR2: state_d = (idx_p1 == depth_q) ? S_ACC : S_UPD_RD;
			S_ACC: state_d = S_AUG_NODE;
			S_OUT: if (out_acc) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			arc_cnt_q  <= '0;
			drop_q     <= 1'b0;
			has_arc_q  <= '0;
			has_next_q <= '0;
			cur_ok_q   <= '0;
			lvl_ok_q   <= '0;
			src_q      <= '0;
			snk_q      <= node_t'(1);
			head_q     <= '0;
			tail_q     <= '0;
			depth_q    <= '0;
			idx_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_SOURCE: src_q <= cfg.data;
					REG_SINK:   snk_q <= cfg.data;
					default:    src_q <= src_q;
				endcase
			end
			if (state_q == S_IDLE && in_acc && bad_edge)
				drop_q <= 1'b1;
			// a fresh arc slot already reads as having no successor
			if (app_en) begin
				arc_cnt_q <= arc_cnt_q + CW'(1);
				if (has_arc_q[app_node])
					has_next_q[last_q[app_node]] <= 1'b1;
				else
					has_arc_q[app_node] <= 1'b1;
			end
			case (state_q)
				S_BFS_INIT: begin
					lvl_ok_q <= MAX_NODES'(1) << src_n;
					head_q   <= '0;
					tail_q   <= DW'(1);
				end
				S_BFS_POP:
					if (head_q != tail_q) head_q <= head_q + DW'(1);
				S_BFS_CHK:
					if (!lvl_ok_rd && res_rd_q != '0) begin
						lvl_ok_q[t_n] <= 1'b1;
						if (int'(tail_q) < MAX_NODES) tail_q <= tail_q + DW'(1);
					end
				S_BFS_DONE: begin
					cur_ok_q <= has_arc_q;
					depth_q  <= '0;
				end
				S_AUG_NODE:
					if (u_q == snk_n) idx_q <= '0;
					else if (!cur_ok_q[u_q] && depth_q != '0) depth_q <= depth_m1;
				S_AUG_CHK:
					if (aug_ok) depth_q <= depth_q + DW'(1);
					else cur_ok_q[u_q] <= has_next_q[cur_u];
				S_AUG_ADV: cur_ok_q[u_q] <= has_next_q[cur_u];
				S_MIN_CHK: idx_q <= (idx_p1 == depth_q) ? '0 : idx_p1;
				S_UPD_WR2: idx_q <= idx_p1;
				S_ACC: depth_q <= '0;
				S_OUT:
					if (out_acc) begin
						arc_cnt_q  <= '0;
						drop_q     <= 1'b0;
						has_arc_q  <= '0;
						has_next_q <= '0;
					end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			last_q2 <= edge_in.last_edge;
			v_q     <= in_v;
			u2_q    <= in_u;
		end
		if (app_en) begin
			if (!has_arc_q[app_node]) first_q[app_node] <= app_addr;
			last_q[app_node] <= app_addr;
		end
		case (state_q)
			S_START: total_q <= '0;
			S_BFS_INIT: begin
				lvl_q[src_n] <= '0;
				queue_q[0]   <= src_n;
			end
			S_BFS_POP:
				if (head_q != tail_q) begin
					u_q     <= pop_u;
					lvl_u_q <= lvl_rd;
					a_q     <= first_q[pop_u];
				end
			S_BFS_CHK: begin
				if (!lvl_ok_rd && res_rd_q != '0) begin
					lvl_q[t_n] <= lvl_u_q + LW'(1);
					if (int'(tail_q) < MAX_NODES) queue_q[tail_q[NIW-1:0]] <= t_n;
				end
				a_q <= nxt_rd_q;
			end
			S_BFS_DONE: begin
				for (int i = 0; i < MAX_NODES; i++)
					cursor_q[i] <= first_q[i];
				u_q <= src_n;
			end
			S_AUG_NODE: begin
				lvl_u_q    <= lvl_rd;
				lvl_u_ok_q <= lvl_ok_rd;
				b_q        <= CAP_MAX;
				if (u_q != snk_n && !cur_ok_q[u_q] && depth_q != '0)
					u_q <= ret_u;
			end
			S_AUG_CHK:
				if (aug_ok) begin
					path_arc_q[depth_q[NIW-1:0]]  <= cur_u;
					path_node_q[depth_q[NIW-1:0]] <= u_q;
					u_q <= t_n;
				end else begin
					cursor_q[u_q] <= nxt_rd_q;
				end
			S_AUG_ADV: cursor_q[u_q] <= nxt_rd_q;
			S_MIN_CHK:
				if (alu_sum[ALU_BITS-1]) b_q <= res_rd_q;
			S_UPD_RD: a_q <= path_arc_q[idx_q[NIW-1:0]];
			S_UPD_WR1: par_q <= par_rd_q;
			S_ACC: begin
				total_q <= alu_sum[FLOW_BITS-1:0];
				u_q     <= src_n;
			end
			default: par_q <= par_q;
		endcase
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> !edge_in.ready)
		else $error("result pending while input open");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(depth_q) <= MAX_NODES)
		else $error("path stack overrun");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(arc_cnt_q) <= ARCS)
		else $error("arc count beyond store");

	a_clear_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |=> (arc_cnt_q == '0 && !drop_q && has_arc_q == '0))
		else $error("arc store not cleared after result");

endmodule

// ===== design/mflg_alu.sv =====
module mflg_alu (
	input  mflg_pkg::alu_op_t   op,
	input  mflg_pkg::alu_word_t x,
	input  mflg_pkg::alu_word_t y,
	output mflg_pkg::alu_word_t sum
);
	import mflg_pkg::*;

	// one adder serves min compare, residual update and flow accumulation
	always_comb begin
		case (op)
			ALU_ADD: sum = x + y;
			ALU_SUB: sum = x + ~y + ALU_BITS'(1);
			default: sum = x + y;
		endcase
	end

endmodule

// ===== tb/sv/max_flow_level_graph_checker.sv =====
module max_flow_level_graph_checker
	import mflg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	mflg_edge_if  edge_in,
	mflg_result_if result_out,
	mflg_cfg_if   cfg,
	output int    fail_count,
	output int    flows_pending
);

	localparam int ARCS = 2 * MAX_EDGES_DEF;
	localparam int NO_LVL = 255;

	node_t src_reg, snk_reg;
	node_t arc_to[ARCS];
	int arc_cap[ARCS];
	int node_arcs[MAX_NODES_DEF][$];
	int n_arcs;
	bit dropped;
	int lvl[MAX_NODES_DEF];
	int cur[MAX_NODES_DEF];
	int path[$];

	typedef struct {
		flow_t flow;
		logic  drop;
	} flow_result_t;
	flow_result_t expected_flows[$];

	function automatic bit build_levels();
		int q[$];
		int u;
		foreach (lvl[i]) lvl[i] = NO_LVL;
		lvl[src_reg] = 0;
		q = {q, int'(src_reg)};
		while (q.size() > 0) begin
			u = q.pop_front();
			for (int k = 0; k < node_arcs[u].size(); k++) begin
				int a;
				a = node_arcs[u][k];
				if (lvl[arc_to[a]] == NO_LVL && arc_cap[a] > 0) begin
					lvl[arc_to[a]] = lvl[u] + 1;
					q = {q, int'(arc_to[a])};
				end
			end
		end
		return lvl[snk_reg] != NO_LVL;
	endfunction

	// DFS with cursors; cursor indexes into the node's arc list
	function automatic longint push_path();
		int u, a, b;
		bit found;
		u = src_reg;
		path.delete();
		forever begin
			if (u == snk_reg) begin
				b = 32'h7fff_ffff;
				foreach (path[i]) if (arc_cap[path[i]] < b) b = arc_cap[path[i]];
				foreach (path[i]) begin
					arc_cap[path[i]] -= b;
					arc_cap[path[i] ^ 1] += b;
				end
				return b;
			end
			found = 0;
			while (cur[u] < node_arcs[u].size()) begin
				a = node_arcs[u][cur[u]];
				if (path.size() < MAX_NODES_DEF && arc_cap[a] > 0 &&
						lvl[u] != NO_LVL && lvl[arc_to[a]] == lvl[u] + 1) begin
					found = 1;
					break;
				end
				cur[u]++;
			end
			if (found) begin
				path = {path, a};
				u = arc_to[a];
			end else begin
				if (path.size() == 0) return 0;
				a = path.pop_back();
				u = arc_to[a ^ 1];
				cur[u]++;
			end
		end
	endfunction

	function automatic longint compute_flow();
		longint total, p;
		total = 0;
		if (src_reg == snk_reg) return 0;
		while (build_levels()) begin
			foreach (cur[i]) cur[i] = 0;
			p = push_path();
			while (p != 0) begin
				total += p;
				p = push_path();
			end
		end
		return total;
	endfunction

	task automatic store_edge(node_t t, node_t h, cap_in_t c);
		if (n_arcs + 2 > ARCS) begin
			dropped = 1;
		end else begin
			arc_to[n_arcs] = h;
			arc_cap[n_arcs] = int'(c);
			node_arcs[t] = {node_arcs[t], n_arcs};
			arc_to[n_arcs + 1] = t;
			arc_cap[n_arcs + 1] = 0;
			node_arcs[h] = {node_arcs[h], n_arcs + 1};
			n_arcs += 2;
		end
	endtask

	function automatic void clear_graph();
		foreach (node_arcs[i]) node_arcs[i].delete();
		n_arcs = 0;
		dropped = 0;
	endfunction

	assign flows_pending = expected_flows.size();

	always @(posedge clk or negedge arst_n) begin
		flow_result_t r;
		if (!arst_n) begin
			src_reg <= '0;
			snk_reg <= 4'd1;
			fail_count <= 0;
			clear_graph();
			expected_flows.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SOURCE) src_reg <= cfg.data;
				else snk_reg <= cfg.data;
			end
			if (edge_in.valid && edge_in.ready) begin
				store_edge(edge_in.tail_node, edge_in.head_node, edge_in.edge_capacity);
				if (edge_in.last_edge) begin
					r.flow = flow_t'(compute_flow());
					r.drop = dropped;
					expected_flows = {expected_flows, r};
					clear_graph();
				end
			end
			if (result_out.valid && result_out.ready) begin
				if (expected_flows.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected flow result %0d", result_out.total_flow);
					fail_count <= fail_count + 1;
				end else begin
					r = expected_flows.pop_front();
					if (r.flow !== result_out.total_flow || r.drop !== result_out.edges_dropped) begin
						if (fail_count < 10)
							$display("flow mismatch: exp %0d/%0b got %0d/%0b", r.flow, r.drop,
								result_out.total_flow, result_out.edges_dropped);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/max_flow_level_graph_test.sv =====
module max_flow_level_graph_test;
	import mflg_pkg::*;

	logic clk;
	logic arst_n;
	int fail_count;
	int flows_pending;
	int send_idle_pct, recv_stall_pct;
	longint cycle_count;

	mflg_edge_if   edge_ch();
	mflg_result_if result_ch();
	mflg_cfg_if    cfg_ch();

	max_flow_level_graph u_top (
		.clk(clk), .arst_n(arst_n),
		.edge_in(edge_ch), .result_out(result_ch), .cfg(cfg_ch)
	);

	max_flow_level_graph_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.edge_in(edge_ch), .result_out(result_ch), .cfg(cfg_ch),
		.fail_count(fail_count), .flows_pending(flows_pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		edge_ch.valid = 0;
		edge_ch.tail_node = '0;
		edge_ch.head_node = '0;
		edge_ch.edge_capacity = '0;
		edge_ch.last_edge = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_SOURCE;
		cfg_ch.data = '0;
		result_ch.ready = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (arst_n)
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 20_000_000) begin
			$display("[max_flow_level_graph] ERROR");
			$finish;
		end
	end
	initial cycle_count = 0;

	// valid stays high from one item to the next unless the sender idles
	task automatic send_edge(node_t t, node_t h, cap_in_t c, logic last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			edge_ch.valid <= 0;
			@(posedge clk);
		end
		edge_ch.valid <= 1;
		edge_ch.tail_node <= t;
		edge_ch.head_node <= h;
		edge_ch.edge_capacity <= c;
		edge_ch.last_edge <= last;
		@(posedge clk);
		while (!edge_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, node_t v);
		edge_ch.valid <= 0;
		@(posedge clk);
		while (flows_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 0;
	endtask

	task automatic random_edge(logic last);
		cap_in_t c;
		case ($urandom_range(3))
			0: c = cap_in_t'($urandom_range(20));
			1: c = cap_in_t'($urandom);
			2: c = cap_in_t'(31'h7fff_ffff - $urandom_range(3));
			default: c = cap_in_t'($urandom_range(1000));
		endcase
		send_edge(node_t'($urandom), node_t'($urandom), c, last);
	endtask

	task automatic random_graph(int n);
		for (int i = 0; i < n; i++) random_edge(i == n - 1);
	endtask

	initial begin
		int phase, sent, n;
		@(posedge arst_n);
		@(posedge clk);
		// simple chain 0->2->1, saturating caps, self-loop, zero cap
		send_edge(4'd0, 4'd2, 31'h7fff_ffff, 1'b0);
		send_edge(4'd2, 4'd2, 31'd5, 1'b0);
		send_edge(4'd0, 4'd1, 31'd0, 1'b0);
		send_edge(4'd2, 4'd1, 31'h7fff_ffff, 1'b1);
		// parallel max edges into sink
		send_edge(4'd0, 4'd1, 31'h7fff_ffff, 1'b0);
		send_edge(4'd0, 4'd1, 31'h7fff_ffff, 1'b0);
		send_edge(4'd0, 4'd1, 31'h7fff_ffff, 1'b1);
		// store overflow: edges past the arc store's capacity are dropped
		for (int i = 0; i < 66; i++)
			send_edge(node_t'(i % 16), node_t'((i + 1) % 16), cap_in_t'(i + 1), i == 65);
		send_edge(4'd15, 4'd15, 31'd1, 1'b1);
		write_reg(REG_SOURCE, 4'd15);
		write_reg(REG_SINK, 4'd15);
		send_edge(4'd15, 4'd0, 31'd9, 1'b1);
		write_reg(REG_SINK, 4'd0);
		send_edge(4'd15, 4'd0, 31'd9, 1'b1);
		write_reg(REG_SOURCE, 4'd0);
		write_reg(REG_SINK, 4'd1);

		sent = 0;
		phase = 0;
		while (sent < 1300) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 67; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 67; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (int g = 0; g < 8; g++) begin
				n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 24);
				random_graph(n);
				sent += n;
			end
			if (phase % 3 == 2) begin
				write_reg(REG_SOURCE, node_t'($urandom));
				write_reg(REG_SINK, node_t'($urandom));
			end
			phase++;
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		edge_ch.valid <= 0;
		@(posedge clk);
		while (flows_pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("[max_flow_level_graph] OK");
		else
			$display("[max_flow_level_graph] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/mflg_pkg.sv
design/mflg_intf.sv
design/mflg_alu.sv
design/max_flow_level_graph.sv
tb/sv/max_flow_level_graph_checker.sv
tb/sv/max_flow_level_graph_test.sv
